### hdl/assert_macros.svh
// Assertion macros shared by the RTL of the shuffled lagged Fibonacci generator.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge outside reset.
`define ASSERT_CLK(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Expression must never be true outside reset.
`define ASSERT_NEVER(label, clk, rst, expr, msg) \
   label: assert property (@(posedge clk) disable iff (rst) !(expr)) else $error(msg);

`endif

### hdl/lfsur_pkg.sv
// Package: constants, codes and helpers of the shuffled lagged Fibonacci generator.
`timescale 1ns / 1ps

package lfsur_pkg;

   localparam int WORD_BITS      = 32;
   localparam int SPAN_BITS      = WORD_BITS + 1;
   localparam int LAG_DEPTH      = 55;
   localparam int SHUFFLE_DEPTH  = 256;
   localparam int RESULT_BITS    = 31;
   localparam int LAG_ADDR_BITS  = $clog2(LAG_DEPTH);
   localparam int SHUF_ADDR_BITS = $clog2(SHUFFLE_DEPTH);
   localparam int DIV_CNT_BITS   = $clog2(RESULT_BITS + 1);
   localparam int SHORT_START    = 23;
   localparam int LONG_START     = LAG_DEPTH - 1;
   localparam int LAG_GAP        = LONG_START - SHORT_START;

   // Command codes on req_cmd
   localparam logic CMD_RESEED = 1'b0;
   localparam logic CMD_DRAW   = 1'b1;

   // Lag index step: count down, wrap to the top entry
   function automatic logic [LAG_ADDR_BITS-1:0] lag_dec(input logic [LAG_ADDR_BITS-1:0] idx);
      logic [LAG_ADDR_BITS-1:0] res;
      if (idx == '0 || idx >= LAG_ADDR_BITS'(LAG_DEPTH))
         res = LAG_ADDR_BITS'(LAG_DEPTH - 1);
      else
         res = idx - LAG_ADDR_BITS'(1);
      return res;
   endfunction

endpackage

### hdl/lagged_fib_shuffled_uniform_rng.sv
// Top level: lagged Fibonacci (24, 55) generator with shuffle table, uniform draw in range.
`timescale 1ns / 1ps

// Channel  | Direction | Handshake            | Payload
// req_     | in        | req_valid/req_stall  | cmd, seed_value, range_low, range_high
// rsp_     | out       | rsp_valid/rsp_stall  | random_value (draws only)
//
// Draw: the result is set by the bit-serial remainder unit; req_stall drops in the
// same cycle as rsp_valid rises. Equal bounds skip it: ST_PREP goes straight to ST_FIN.
// Reseed: 55 lag entries filled, then 513 lag steps through ST_STEP0 to ST_STEP2, with
// operands read in turn via the one lag RAM read port. Reset runs the same pass with seed 0.
// req_stall is high whenever a transaction is in flight. rsp_stall holds the rsp
// register; a further result then waits in ST_FIN and keeps req_stall high.

module lagged_fib_shuffled_uniform_rng import lfsur_pkg::*; (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_stall,
   input  logic                        req_cmd,
   input  logic [WORD_BITS-1:0]        req_seed_value,
   input  logic signed [WORD_BITS-1:0] req_range_low,
   input  logic signed [WORD_BITS-1:0] req_range_high,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic signed [WORD_BITS-1:0] rsp_random_value
);

`include "assert_macros.svh"

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_FILL,       // reseed: write lag table Fibonacci-style
      ST_STEP0,      // lag step: read short entry
      ST_STEP1,      // lag step: latch short, read long entry
      ST_STEP2,      // lag step: add, write back, route result
      ST_PREP,       // order bounds, catch equal bounds
      ST_SHUF_RD,    // read shuffle entry, form span
      ST_SHUF_TAKE,  // swap selector, kick remainder unit
      ST_DIV_WAIT,
      ST_FIN
   } state_type;

   // where a lag step's result goes
   typedef enum logic [1:0] {
      PH_DISCARD,
      PH_FILL,
      PH_SEL,
      PH_DRAW
   } phase_type;

   state_type                 state_ff;
   phase_type                 phase_ff;
   logic [SHUF_ADDR_BITS-1:0] cnt_ff;
   logic [LAG_ADDR_BITS-1:0]  short_ff;
   logic [LAG_ADDR_BITS-1:0]  long_ff;
   logic [WORD_BITS-1:0]      a_ff;
   logic [WORD_BITS-1:0]      b_ff;
   logic [WORD_BITS-1:0]      opnd_ff;
   logic [WORD_BITS-1:0]      selector_ff;
   logic [SHUF_ADDR_BITS-1:0] k_ff;
   logic [WORD_BITS-1:0]      low_ff;
   logic [WORD_BITS-1:0]      high_ff;
   logic [SPAN_BITS-1:0]      span_ff;
   logic [WORD_BITS-1:0]      res_ff;
   logic                      rsp_valid_ff;
   logic [WORD_BITS-1:0]      rsp_value_ff;
   logic                      div_start_ff;

   // lag RAM port
   logic                      lag_we;
   logic [LAG_ADDR_BITS-1:0]  lag_waddr;
   logic [WORD_BITS-1:0]      lag_wdata;
   logic [LAG_ADDR_BITS-1:0]  lag_raddr;
   logic [WORD_BITS-1:0]      lag_rdata;

   // shuffle RAM port
   logic                      shuf_we;
   logic [SHUF_ADDR_BITS-1:0] shuf_waddr;
   logic [SHUF_ADDR_BITS-1:0] shuf_raddr;
   logic [WORD_BITS-1:0]      shuf_rdata;

   // shared adder
   logic [WORD_BITS-1:0]      add_a;
   logic [WORD_BITS-1:0]      add_b;
   logic [WORD_BITS-1:0]      add_sum;

   logic                      div_done;
   logic [RESULT_BITS-1:0]    div_rem;
   logic                      req_take;
   logic                      rsp_take;
   logic                      rsp_free;

   // assertion helpers
   logic                      lag_waddr_bad;
   logic                      lag_gap_ok;
   logic                      in_fin;

   assign req_take = req_valid && !req_stall;
   assign rsp_take = rsp_valid_ff && !rsp_stall;
   assign rsp_free = !rsp_valid_ff || !rsp_stall;

   // One 32-bit adder: Fibonacci fill during reseed, lag sum otherwise
   always_comb begin
      if (state_ff == ST_FILL) begin
         add_a = a_ff;
         add_b = b_ff;
      end else begin
         add_a = lag_rdata;
         add_b = opnd_ff;
      end
      add_sum = add_a + add_b;
   end

   always_comb begin
      lag_we    = (state_ff == ST_FILL) || (state_ff == ST_STEP2);
      lag_waddr = (state_ff == ST_FILL) ? cnt_ff[LAG_ADDR_BITS-1:0] : long_ff;
      lag_wdata = (state_ff == ST_FILL) ? a_ff : add_sum;
      lag_raddr = (state_ff == ST_STEP0) ? lag_dec(short_ff) : long_ff;
   end

   always_comb begin
      shuf_we    = (state_ff == ST_STEP2) && ((phase_ff == PH_FILL) || (phase_ff == PH_DRAW));
      shuf_waddr = (phase_ff == PH_FILL) ? cnt_ff : k_ff;
      shuf_raddr = selector_ff[WORD_BITS-1 -: SHUF_ADDR_BITS];
   end

   lfsur_ram #(
      .WIDTH (WORD_BITS),
      .DEPTH (LAG_DEPTH)
   ) u_lag_ram (
      .clock   (clock),
      .wr_en   (lag_we),
      .wr_addr (lag_waddr),
      .wr_data (lag_wdata),
      .rd_addr (lag_raddr),
      .rd_data (lag_rdata)
   );

   lfsur_ram #(
      .WIDTH (WORD_BITS),
      .DEPTH (SHUFFLE_DEPTH)
   ) u_shuf_ram (
      .clock   (clock),
      .wr_en   (shuf_we),
      .wr_addr (shuf_waddr),
      .wr_data (add_sum),
      .rd_addr (shuf_raddr),
      .rd_data (shuf_rdata)
   );

   // draw value is the leaving word's low RESULT_BITS bits
   lfsur_div u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start_ff),
      .dividend  (shuf_rdata[RESULT_BITS-1:0]),
      .divisor   (span_ff),
      .done      (div_done),
      .remainder (div_rem)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         // reset behaves as a reseed with zero
         state_ff     <= ST_FILL;
         phase_ff     <= PH_DISCARD;
         cnt_ff       <= '0;
         a_ff         <= WORD_BITS'(1);
         b_ff         <= '0;
         short_ff     <= LAG_ADDR_BITS'(SHORT_START);
         long_ff      <= LAG_ADDR_BITS'(LONG_START);
         rsp_valid_ff <= 1'b0;
         div_start_ff <= 1'b0;
      end else begin
         div_start_ff <= 1'b0;
         // ST_FIN reloads the register itself when it is free
         if (rsp_take && (state_ff != ST_FIN)) begin
            rsp_valid_ff <= 1'b0;
         end

         unique case (state_ff)
            ST_IDLE: begin
               if (req_take) begin
                  if (req_cmd == CMD_RESEED) begin
                     a_ff     <= WORD_BITS'(1);
                     b_ff     <= req_seed_value;
                     cnt_ff   <= '0;
                     state_ff <= ST_FILL;
                  end else begin
                     low_ff   <= req_range_low;
                     high_ff  <= req_range_high;
                     state_ff <= ST_PREP;
                  end
               end
            end

            ST_FILL: begin
               a_ff <= b_ff;
               b_ff <= add_sum;
               if (cnt_ff == SHUF_ADDR_BITS'(LAG_DEPTH - 1)) begin
                  cnt_ff   <= '0;
                  short_ff <= LAG_ADDR_BITS'(SHORT_START);
                  long_ff  <= LAG_ADDR_BITS'(LONG_START);
                  phase_ff <= PH_DISCARD;
                  state_ff <= ST_STEP0;
               end else begin
                  cnt_ff <= cnt_ff + SHUF_ADDR_BITS'(1);
               end
            end

            ST_STEP0: begin
               short_ff <= lag_dec(short_ff);
               long_ff  <= lag_dec(long_ff);
               state_ff <= ST_STEP1;
            end

            ST_STEP1: begin
               opnd_ff  <= lag_rdata;
               state_ff <= ST_STEP2;
            end

            ST_STEP2: begin
               unique case (phase_ff)
                  PH_DISCARD: begin
                     if (cnt_ff == SHUF_ADDR_BITS'(SHUFFLE_DEPTH - 1)) begin
                        phase_ff <= PH_FILL;   // fill runs from the top entry down
                     end else begin
                        cnt_ff <= cnt_ff + SHUF_ADDR_BITS'(1);
                     end
                     state_ff <= ST_STEP0;
                  end
                  PH_FILL: begin
                     if (cnt_ff == '0) begin
                        phase_ff <= PH_SEL;
                     end else begin
                        cnt_ff <= cnt_ff - SHUF_ADDR_BITS'(1);
                     end
                     state_ff <= ST_STEP0;
                  end
                  PH_SEL: begin
                     selector_ff <= add_sum;
                     state_ff    <= ST_IDLE;
                  end
                  PH_DRAW: begin
                     state_ff <= ST_DIV_WAIT;
                  end
                  default: begin
                     state_ff <= ST_IDLE;
                  end
               endcase
            end

            ST_PREP: begin
               if (low_ff == high_ff) begin
                  res_ff   <= low_ff;
                  state_ff <= ST_FIN;
               end else begin
                  if ($signed(low_ff) > $signed(high_ff)) begin
                     low_ff  <= high_ff;
                     high_ff <= low_ff;
                  end
                  state_ff <= ST_SHUF_RD;
               end
            end

            ST_SHUF_RD: begin
               // span in 33 bits: full 32-bit range gives 2^32
               span_ff  <= {high_ff[WORD_BITS-1], high_ff} - {low_ff[WORD_BITS-1], low_ff}
                           + SPAN_BITS'(1);
               k_ff     <= shuf_raddr;
               state_ff <= ST_SHUF_TAKE;
            end

            ST_SHUF_TAKE: begin
               selector_ff  <= shuf_rdata;
               div_start_ff <= 1'b1;
               phase_ff     <= PH_DRAW;
               state_ff     <= ST_STEP0;
            end

            ST_DIV_WAIT: begin
               if (div_done && !div_start_ff) begin
                  res_ff   <= low_ff + WORD_BITS'(div_rem);
                  state_ff <= ST_FIN;
               end
            end

            ST_FIN: begin
               if (rsp_free) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_value_ff <= res_ff;
                  state_ff     <= ST_IDLE;
               end
            end

            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign req_stall        = (state_ff != ST_IDLE);
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_random_value = $signed(rsp_value_ff);

   assign lag_waddr_bad = lag_we && (lag_waddr > LAG_ADDR_BITS'(LAG_DEPTH - 1));
   assign lag_gap_ok    = (long_ff == short_ff + LAG_ADDR_BITS'(LAG_GAP))
                          || (short_ff == long_ff + LAG_ADDR_BITS'(LAG_DEPTH - LAG_GAP));
   assign in_fin        = (state_ff == ST_FIN);

   `ASSERT_NEVER(lag_waddr_range, clock, reset, lag_waddr_bad, "lag write address out of range")

   `ASSERT_CLK(lag_index_gap, clock, reset, lag_gap_ok, "lag indices lost their spacing")

   `ASSERT_CLK(rsp_from_fin, clock, reset, $rose(rsp_valid_ff) |-> $past(in_fin), "rsp not from FIN")

endmodule

### hdl/lfsur_ram.sv
// Generic simple dual-port RAM: one write port, one registered read port.
`timescale 1ns / 1ps

module lfsur_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64,
   localparam int ADDR_BITS = $clog2(DEPTH)
) (
   input  logic                 clock,
   input  logic                 wr_en,
   input  logic [ADDR_BITS-1:0] wr_addr,
   input  logic [WIDTH-1:0]     wr_data,
   input  logic [ADDR_BITS-1:0] rd_addr,
   output logic [WIDTH-1:0]     rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

### hdl/lfsur_div.sv
// Bit-serial remainder unit: one dividend bit per cycle.
`timescale 1ns / 1ps

module lfsur_div import lfsur_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   input  logic [RESULT_BITS-1:0] dividend,
   input  logic [SPAN_BITS-1:0]   divisor,
   output logic                   done,
   output logic [RESULT_BITS-1:0] remainder
);

`include "assert_macros.svh"

   logic                    busy_ff;
   logic                    done_ff;
   logic [DIV_CNT_BITS-1:0] cnt_ff;
   logic [RESULT_BITS-1:0]  rem_ff;
   logic [RESULT_BITS-1:0]  dvd_ff;
   logic [SPAN_BITS-1:0]    dsr_ff;

   logic [SPAN_BITS-1:0]    trial;
   logic [SPAN_BITS-1:0]    trial_diff;
   logic [RESULT_BITS-1:0]  rem_in;

   // partial remainder never exceeds the dividend prefix, so it fits RESULT_BITS
   always_comb begin
      trial      = SPAN_BITS'({rem_ff, dvd_ff[RESULT_BITS-1]});
      trial_diff = trial - dsr_ff;
      if (trial >= dsr_ff)
         rem_in = trial_diff[RESULT_BITS-1:0];
      else
         rem_in = trial[RESULT_BITS-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else if (start) begin
         busy_ff <= 1'b1;
         done_ff <= 1'b0;
         cnt_ff  <= DIV_CNT_BITS'(RESULT_BITS);
         rem_ff  <= '0;
         dvd_ff  <= dividend;
         dsr_ff  <= divisor;
      end else if (busy_ff) begin
         rem_ff <= rem_in;
         dvd_ff <= {dvd_ff[RESULT_BITS-2:0], 1'b0};
         cnt_ff <= cnt_ff - DIV_CNT_BITS'(1);
         if (cnt_ff == DIV_CNT_BITS'(1)) begin
            busy_ff <= 1'b0;
            done_ff <= 1'b1;
         end
      end
   end

   assign done      = done_ff;
   assign remainder = rem_ff;

   `ASSERT_NEVER(div_busy_and_done, clock, reset, busy_ff && done_ff, "div busy while done")

endmodule
